// ----- rtl/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

    // Coordinate width; the stream field widths below are derived from it.
    localparam int COORD_BITS = 10;

    // Stream packing: four coordinates in, two coordinates out padded to bytes.
    localparam int IN_TDATA_W  = 4 * COORD_BITS;
    localparam int OUT_FIELD_W = 2 * COORD_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Word kinds carried on the input tuser bit.
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch endpoints, emit the first pixel
        logic div_step;  // one restoring division step for both axes
        logic advance;   // add increments, emit the next pixel
    } dda_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_len;   // the endpoints on the input bus are equal
        logic div_last;   // the current division step is the final one
        logic last_step;  // the next advance reaches the endpoint
    } dda_stat_t;

endpackage

`default_nettype wire

// ----- rtl/dda_line_generator.sv -----
// DDA line rasterizer with stream input and output.
// The input word carries tuser = kind: a start word loads the two endpoints
// from tdata and produces the first pixel; an advance word steps one pixel.
// An advance word that arrives while no line is in progress is consumed and
// produces nothing. Each result word carries the pixel position in tdata and
// tlast set on the final pixel of the line.
// A start word shows its pixel on the output in the cycle after acceptance. The
// per-step increments are then formed by a restoring divider that retires one
// quotient bit per cycle for both axes, so the input holds tready low while
// the division runs after a start word with distinct endpoints. A start word
// with equal endpoints gives one pixel with tlast set and needs no division.
// After that, advance words are taken one per cycle while the receiver keeps
// up, and each gives its pixel in the following cycle.
// The single output register lets a new word enter in the same cycle the
// pending result is taken; while the receiver stalls, the input stalls too.
// Reset clears the controller to idle with no result pending.
`default_nettype none

module dda_line_generator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0 up: x_start, y_start, x_end, y_end.
    input  wire logic [dda_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Field: kind (start or advance).
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // Fields from bit 0 up: pixel_x, pixel_y, then zero padding.
    output logic [dda_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tlast
);
    import dda_pkg::*;

    dda_cmd_t  cmd;
    dda_stat_t stat;

    // The controller sequences line start, division and pixel stepping.
    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the accumulators, the divider and the result word.
    dda_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/dda_ctrl.sv -----
`default_nettype none

module dda_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_kind,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output dda_pkg::dda_cmd_t      cmd,
    input  wire dda_pkg::dda_stat_t stat
);
    import dda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;

    always_comb
    begin
        s_tready      = (state_reg != ST_DIV) && (!m_tvalid_reg || m_tready);
        accept        = s_tvalid && s_tready;
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE, ST_RUN:
            begin
                if (accept)
                begin
                    if (s_kind == KIND_START)
                    begin
                        cmd.load      = 1'b1;
                        m_tvalid_next = 1'b1;
                        state_next    = stat.zero_len ? ST_IDLE : ST_DIV;
                    end
                    else if (state_reg == ST_RUN)
                    begin
                        cmd.advance   = 1'b1;
                        m_tvalid_next = 1'b1;
                        state_next    = stat.last_step ? ST_IDLE : ST_RUN;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ----- rtl/dda_datapath.sv -----
`default_nettype none

module dda_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dda_pkg::dda_cmd_t               cmd,
    output dda_pkg::dda_stat_t                   stat,
    input  wire logic [dda_pkg::IN_TDATA_W-1:0]  in_data,
    output logic [dda_pkg::OUT_TDATA_W-1:0]      out_data,
    output logic                                 out_last
);
    import dda_pkg::*;

    localparam int AW  = COORD_BITS + FRAC_BITS + 1;  // accumulator, signed
    localparam int IW  = FRAC_BITS + 2;               // increment, signed
    localparam int QW  = FRAC_BITS + 1;               // quotient magnitude
    localparam int CW  = COORD_BITS + 1;              // deltas and step counts
    localparam int DCW = $clog2(FRAC_BITS + 1);

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [CW-1:0]         dx, dy, adx, ady, s_len;

    logic [AW-1:0]  acc_x_reg, acc_y_reg, acc_x_next, acc_y_next;
    logic [IW-1:0]  inc_x_reg, inc_y_reg, inc_x_next, inc_y_next;
    logic [CW-1:0]  step_total_reg, step_done_reg, step_inc;
    logic [CW-1:0]  rem_x_reg, rem_y_reg, r1_x, r1_y;
    logic [QW-1:0]  q_x_reg, q_y_reg, q_x_next, q_y_next;
    logic           neg_x_reg, neg_y_reg, ge_x, ge_y;
    logic [DCW-1:0] div_cnt_reg;

    logic [COORD_BITS-1:0] px_adv, py_adv;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic                  last_reg;

    assign xs = in_data[0*COORD_BITS +: COORD_BITS];
    assign ys = in_data[1*COORD_BITS +: COORD_BITS];
    assign xe = in_data[2*COORD_BITS +: COORD_BITS];
    assign ye = in_data[3*COORD_BITS +: COORD_BITS];

    always_comb
    begin
        dx    = {1'b0, xe} - {1'b0, xs};
        dy    = {1'b0, ye} - {1'b0, ys};
        adx   = dx[CW-1] ? (~dx + CW'(1)) : dx;
        ady   = dy[CW-1] ? (~dy + CW'(1)) : dy;
        s_len = (adx > ady) ? adx : ady;

        // Restoring division of |d| * 2^FRAC_BITS by the step count. Since
        // |d| never exceeds the step count, only FRAC_BITS + 1 quotient bits
        // can be set, so the remainder starts at |d| itself.
        ge_x     = (rem_x_reg >= step_total_reg);
        ge_y     = (rem_y_reg >= step_total_reg);
        r1_x     = ge_x ? (rem_x_reg - step_total_reg) : rem_x_reg;
        r1_y     = ge_y ? (rem_y_reg - step_total_reg) : rem_y_reg;
        q_x_next = {q_x_reg[QW-2:0], ge_x};
        q_y_next = {q_y_reg[QW-2:0], ge_y};
        inc_x_next = neg_x_reg ? (~{1'b0, q_x_next} + IW'(1)) : {1'b0, q_x_next};
        inc_y_next = neg_y_reg ? (~{1'b0, q_y_next} + IW'(1)) : {1'b0, q_y_next};

        acc_x_next = acc_x_reg + {{(AW-IW){inc_x_reg[IW-1]}}, inc_x_reg};
        acc_y_next = acc_y_reg + {{(AW-IW){inc_y_reg[IW-1]}}, inc_y_reg};
        px_adv     = acc_x_next[AW-1] ? '0 : acc_x_next[FRAC_BITS +: COORD_BITS];
        py_adv     = acc_y_next[AW-1] ? '0 : acc_y_next[FRAC_BITS +: COORD_BITS];
        step_inc   = step_done_reg + CW'(1);

        stat.zero_len  = (s_len == '0);
        stat.div_last  = (div_cnt_reg == '0);
        stat.last_step = (step_inc >= step_total_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= DCW'(FRAC_BITS);
        end
        else if (cmd.div_step && (div_cnt_reg != '0))
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_x_reg      <= {1'b0, xs, {FRAC_BITS{1'b0}}};
            acc_y_reg      <= {1'b0, ys, {FRAC_BITS{1'b0}}};
            inc_x_reg      <= '0;
            inc_y_reg      <= '0;
            step_total_reg <= s_len;
            step_done_reg  <= '0;
            rem_x_reg      <= adx;
            rem_y_reg      <= ady;
            q_x_reg        <= '0;
            q_y_reg        <= '0;
            neg_x_reg      <= dx[CW-1];
            neg_y_reg      <= dy[CW-1];
            px_reg         <= xs;
            py_reg         <= ys;
            last_reg       <= (s_len == '0);
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= {r1_x[CW-2:0], 1'b0};
            rem_y_reg <= {r1_y[CW-2:0], 1'b0};
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            if (div_cnt_reg == '0)
            begin
                inc_x_reg <= inc_x_next;
                inc_y_reg <= inc_y_next;
            end
        end
        else if (cmd.advance)
        begin
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            step_done_reg <= step_inc;
            px_reg        <= px_adv;
            py_reg        <= py_adv;
            last_reg      <= (step_inc >= step_total_reg);
        end
    end

    assign out_data = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, py_reg, px_reg};
    assign out_last = last_reg;

endmodule

`default_nettype wire

// ----- bench/dda_pixel_checker.sv -----
module dda_pixel_checker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [dda_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dda_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic                             m_tlast,
    output int                                    fail_count,
    output int                                    pending_words
);
    timeunit 1ns;
    timeprecision 1ps;
    import dda_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - OUT_FIELD_W;

    typedef struct packed {
        logic [PAD_W-1:0]      pad;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic                  last;
    } pixel_t;

    pixel_t expected_pixels[$];

    // Rasterizer state: positions and increments in fixed point.
    longint      pos_x, pos_y, step_x, step_y;
    int unsigned steps_total, steps_taken;
    bit          line_active;
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [COORD_BITS-1:0] fixed_to_pixel(input longint pos);
        longint whole;
        if (pos < 0)
            return '0;
        whole = pos >>> FRAC_BITS;
        return whole[COORD_BITS-1:0];
    endfunction

    // Works out the pixel, if any, that one accepted input word produces.
    task automatic rasterize(input logic kind, input logic [IN_TDATA_W-1:0] data);
        longint xs, ys, xe, ye, dx, dy, adx, ady, span, one_px;
        pixel_t px;
        one_px = longint'(1) << FRAC_BITS;
        xs = longint'(data[0 +: COORD_BITS]);
        ys = longint'(data[COORD_BITS +: COORD_BITS]);
        xe = longint'(data[2*COORD_BITS +: COORD_BITS]);
        ye = longint'(data[3*COORD_BITS +: COORD_BITS]);
        px = '0;
        if (kind == KIND_START)
        begin
            dx = xe - xs;
            dy = ye - ys;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            span = (adx > ady) ? adx : ady;
            pos_x = xs * one_px;
            pos_y = ys * one_px;
            steps_taken = 0;
            px.x = xs[COORD_BITS-1:0];
            px.y = ys[COORD_BITS-1:0];
            if (span == 0)
            begin
                // Both endpoints coincide: one pixel, flagged last, no division.
                step_x = 0;
                step_y = 0;
                steps_total = 0;
                line_active = 1'b0;
                px.last = 1'b1;
            end
            else
            begin
                // Signed division truncates toward zero.
                step_x = (dx * one_px) / span;
                step_y = (dy * one_px) / span;
                steps_total = 32'(span);
                line_active = 1'b1;
                px.last = 1'b0;
            end
            expected_pixels.push_back(px);
        end
        else if (line_active)
        begin
            pos_x += step_x;
            pos_y += step_y;
            steps_taken++;
            px.x = fixed_to_pixel(pos_x);
            px.y = fixed_to_pixel(pos_y);
            px.last = (steps_taken >= steps_total);
            if (px.last)
                line_active = 1'b0;
            expected_pixels.push_back(px);
        end
    endtask

    task automatic check_pixel();
        pixel_t seen, want;
        seen.x    = m_tdata[0 +: COORD_BITS];
        seen.y    = m_tdata[COORD_BITS +: COORD_BITS];
        seen.pad  = m_tdata[OUT_TDATA_W-1:OUT_FIELD_W];
        seen.last = m_tlast;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel word: x=%0d y=%0d last=%0b pad=%0h",
                         seen.x, seen.y, seen.last, seen.pad);
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel mismatch: expected x=%0d y=%0d last=%0b pad=%0h,",
                              " got x=%0d y=%0d last=%0b pad=%0h"},
                             want.x, want.y, want.last, want.pad,
                             seen.x, seen.y, seen.last, seen.pad);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pos_x = 0;
            pos_y = 0;
            step_x = 0;
            step_y = 0;
            steps_total = 0;
            steps_taken = 0;
            line_active = 1'b0;
            expected_pixels.delete();
        end
        else
        begin
            // A result leaving at this edge always belongs to an older input word.
            if (m_tvalid && m_tready)
                check_pixel();
            if (s_tvalid && s_tready)
                rasterize(s_tuser, s_tdata);
        end
        pending_words = expected_pixels.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dda_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_WORDS = 1250;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending_words;
    int cycle_count = 0;

    // While a burst flag is set, that side runs with no idle cycles at all.
    // Each flag flips now and then, so long gap-free stretches alternate with
    // stretches of random gaps and stalls.
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;

    always #10 clk = ~clk;

    dda_line_generator #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    dda_pixel_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) pixel_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    // Moves one word into the block. The task is entered at a rising edge and
    // returns at the edge where the word was accepted. When no gap is drawn,
    // tvalid simply stays high from the previous word.
    task automatic send_word(input logic kind,
                             input logic [COORD_BITS-1:0] xs, ys, xe, ye);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ye, xe, ys, xs};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // A start word followed by a number of advance words. The advance words
    // carry random coordinates, which the block must ignore.
    task automatic draw_line(input logic [COORD_BITS-1:0] xs, ys, xe, ye,
                             input int advances);
        send_word(KIND_START, xs, ys, xe, ye);
        repeat (advances)
            send_word(KIND_ADVANCE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom));
    endtask

    // A coordinate within reach of a base point, clamped to the screen.
    function automatic logic [COORD_BITS-1:0] near_coord(input int base, input int reach);
        int v;
        v = base + $urandom_range(0, 2 * reach) - reach;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    // Screen corners are favored so that full-length lines show up.
    function automatic logic [COORD_BITS-1:0] extreme_coord();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return COORD_MAX;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // The receiving side: before each result word it may hold tready low for
    // a random number of cycles, then it keeps tready high until a word leaves.
    initial
    begin : take_results
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                take_burst = !take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : make_stimulus
        logic [COORD_BITS-1:0] xs, ys, xe, ye;
        int dx, dy, span, advances, extra, shape, words_counted, reach;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_START;
        s_tdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An advance right out of reset must be swallowed.
        send_word(KIND_ADVANCE, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        // Zero-length lines at both screen corners; the trailing advance
        // finds the block idle again.
        draw_line('0, '0, '0, '0, 1);
        draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        // Diagonal running toward smaller x from the right edge.
        draw_line(COORD_MAX, '0, COORD_BITS'(COORD_MAX - 3), COORD_BITS'(3), 3);
        // Steep line whose truncated x increment leaves the final pixel one short.
        draw_line('0, '0, COORD_BITS'(1), COORD_BITS'(3), 3);
        // A line cut off by a new start, then a vertical line followed by an
        // advance that must not plot past the flagged last pixel.
        draw_line(COORD_BITS'(10), COORD_BITS'(10), COORD_BITS'(20), COORD_BITS'(14), 2);
        draw_line(COORD_BITS'(3), COORD_BITS'(7), COORD_BITS'(3), COORD_BITS'(9), 3);
        // Horizontal line, and a line running down from the top edge.
        draw_line(COORD_BITS'(100), COORD_BITS'(200), COORD_BITS'(104), COORD_BITS'(200), 4);
        draw_line('0, COORD_MAX, COORD_BITS'(2), COORD_BITS'(COORD_MAX - 5), 5);

        // Random part. Most lines are short; a tenth reach a few hundred
        // pixels and a few span the screen. Some lines are abandoned midway
        // by the next start, and some are followed by advances that the idle
        // block must ignore (those are not counted).
        words_counted = 0;
        while (words_counted < RANDOM_WORDS)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 2)
            begin
                xs = extreme_coord();
                ys = extreme_coord();
                xe = extreme_coord();
                ye = extreme_coord();
            end
            else if (shape < 5)
            begin
                xs = COORD_BITS'($urandom);
                ys = COORD_BITS'($urandom);
                xe = xs;
                ye = ys;
            end
            else
            begin
                reach = (shape < 15) ? 300 : 12;
                xs = COORD_BITS'($urandom);
                ys = COORD_BITS'($urandom);
                xe = near_coord(int'(xs), reach);
                ye = near_coord(int'(ys), reach);
            end

            dx = int'(xe) - int'(xs);
            dy = int'(ye) - int'(ys);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            span = (dx > dy) ? dx : dy;

            advances = span;
            extra = 0;
            if (span > 1 && (shape < 2 ? $urandom_range(0, 4) != 0
                                       : $urandom_range(0, 7) == 0))
            begin
                // Long screen-spanning lines are mostly cut short to keep
                // the run dominated by small lines.
                advances = $urandom_range(1, span - 1);
                if (shape < 2 && advances > 40)
                    advances = $urandom_range(1, 40);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                extra = $urandom_range(1, 3);
            end

            draw_line(xs, ys, xe, ye, advances + extra);
            words_counted += 1 + advances;
        end

        s_tvalid <= 1'b0;

        // Let the checker see the last accepted word, then wait for every expected
        // pixel, then wait on for longer than a division takes, to catch strays.
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (FRAC_BITS + 8) @(posedge clk);

        if (fail_count == 0 && pending_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
